/* sv/rifdd_pkg.sv */
package rifdd_pkg;

  // NCO table geometry
  localparam int TABLE_ADDR_BITS = 10;
  localparam int TABLE_FRAC_BITS = 17;
  localparam int TAB_SIZE        = 1 << TABLE_ADDR_BITS;
  localparam int TAB_QUARTER     = TAB_SIZE >> 2;
  // table values span -2^F .. 2^F, negated sine as well
  localparam int TAB_W           = TABLE_FRAC_BITS + 2;

  localparam int SAMPLE_W = 32;
  localparam int PROD_W   = SAMPLE_W + TAB_W;

  localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q62_HALF_PI = 64'h6487_ED51_10B4_611A;
  localparam int          TAYLOR_TERMS = 14;

  typedef logic        [TABLE_ADDR_BITS-1:0] tab_addr_t;
  typedef logic signed [TAB_W-1:0]           tab_val_t;
  typedef tab_val_t                          cos_tab_t [TAB_SIZE];

  typedef enum logic [1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_Q_INVERT    = 2'd1,
    REG_IQ_EXCHANGE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] c;
    logic [63:0] s;
  } cos_sin_t;

  // (a*b) >> 62, Q2.62 product
  function automatic logic [63:0] mul62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned floor quotient by shift and subtract; table build only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series on the first octant, Q2.62 in and out
  function automatic cos_sin_t taylor(logic [63:0] x);
    logic [63:0] x2, ts, tc, ss, cc, dvs, dvc;
    cos_sin_t    r;
    x2 = mul62(x, x);
    ts = x;
    tc = Q62_ONE;
    ss = x;
    cc = Q62_ONE;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      dvs = 64'((2 * n) * (2 * n + 1));
      dvc = 64'((2 * n - 1) * (2 * n));
      ts  = udiv64(mul62(ts, x2), dvs);
      tc  = udiv64(mul62(tc, x2), dvc);
      if (n % 2 == 1) begin
        ss = ss - ts;
        cc = cc - tc;
      end else begin
        ss = ss + ts;
        cc = cc + tc;
      end
    end
    r.c = cc;
    r.s = ss;
    return r;
  endfunction

  function automatic tab_val_t round_q62(logic [63:0] v);
    logic [63:0] t;
    t = (v + (64'd1 << (61 - TABLE_FRAC_BITS))) >> (62 - TABLE_FRAC_BITS);
    return tab_val_t'(t[TAB_W-1:0]);
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] step, cr, sr;
    cos_sin_t    cs;
    int          quad, r;
    step = Q62_HALF_PI >> (TABLE_ADDR_BITS - 2);
    for (int k = 0; k < TAB_SIZE; k++) begin
      quad = k >> (TABLE_ADDR_BITS - 2);
      r    = k & (TAB_QUARTER - 1);
      if (2 * r <= TAB_QUARTER) begin
        cs = taylor(step * 64'(r));
        cr = cs.c;
        sr = cs.s;
      end else begin
        cs = taylor(step * 64'(TAB_QUARTER - r));
        cr = cs.s;
        sr = cs.c;
      end
      case (quad)
        0:       tab[k] = round_q62(cr);
        1:       tab[k] = -round_q62(sr);
        2:       tab[k] = -round_q62(cr);
        default: tab[k] = round_q62(sr);
      endcase
    end
    return tab;
  endfunction

endpackage

/* sv/rifdd_cos_rom.sv */
module rifdd_cos_rom (
  input  logic                clk,
  input  logic                en,
  input  rifdd_pkg::tab_addr_t cos_addr,
  input  rifdd_pkg::tab_addr_t sin_addr,
  output rifdd_pkg::tab_val_t  cos_val,
  output rifdd_pkg::tab_val_t  sin_val
);
  import rifdd_pkg::*;

  // dual-read cosine ROM, registered outputs
  localparam cos_tab_t COS_TAB = build_cos_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= COS_TAB[cos_addr];
      sin_val <= COS_TAB[sin_addr];
    end
  end

endmodule

/* sv/real_if_downconvert_decimate_top.sv */
// Channel   Handshake            Payload           Notes
// input     in_valid/in_ready    if_sample[31:0]   one real Q1.31 sample per transfer
// output    out_valid/out_ready  i_out, q_out      one I/Q pair per two input transfers
// config    cfg_we               cfg_index, data   write-only, takes effect at once
//
// Accepts one sample per cycle unless the output stalls; one result every second sample.
// Path to out_valid: ROM/sample register (loads at the edge that accepts the second sample
// of a pair), then multiplier, round/saturate and output registers.
// Reset is synchronous, active high: phase 0, pair empty, step 2^30, flags clear.
// Stalls back up stage by stage; empty stages keep taking samples while a result waits.
module real_if_downconvert_decimate_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] if_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] i_out,
  output logic signed [31:0] q_out
);
  import rifdd_pkg::*;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (TABLE_FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(32'sh7fff_ffff);
  localparam logic signed [PROD_W-1:0] SAT_LO   = {{(PROD_W-32){1'b1}}, 32'h8000_0000};
  localparam logic signed [31:0]       MAX32    = 32'sh7fff_ffff;
  localparam logic signed [31:0]       MIN32    = 32'sh8000_0000;

  // configuration registers
  logic [31:0] phase_step;
  logic        q_invert;
  logic        iq_exchange;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= 32'h4000_0000;
      q_invert    <= 1'b0;
      iq_exchange <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:  phase_step  <= cfg_data;
        REG_Q_INVERT:    q_invert    <= cfg_data[0];
        REG_IQ_EXCHANGE: iq_exchange <= cfg_data[0];
        default: ;  // index beyond the register list: ignored
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;
  logic pair_second;
  logic in_xfer, s3_fire;

  assign s3_ready = !s3_valid || !pair_second || !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign in_xfer  = in_valid && in_ready;
  assign s3_fire  = s3_valid && s3_ready;

  // NCO: table index from top bits of the phase, advanced on each transfer
  logic [31:0] phase_acc;
  tab_addr_t   cos_addr, sin_addr;

  assign cos_addr = phase_acc[31 -: TABLE_ADDR_BITS];
  assign sin_addr = cos_addr - tab_addr_t'(TAB_QUARTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= 32'd0;
    end else if (in_xfer) begin
      phase_acc <= phase_acc + phase_step;
    end
  end

  // stage 1: ROM read alongside the sample
  logic signed [31:0] s1_x;
  tab_val_t           s1_cos, s1_sin, s1_nsin;

  rifdd_cos_rom u_rom (
    .clk      (clk),
    .en       (in_xfer),
    .cos_addr (cos_addr),
    .sin_addr (sin_addr),
    .cos_val  (s1_cos),
    .sin_val  (s1_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x <= if_sample;
    end
  end

  assign s1_nsin = -s1_sin;

  // stage 2: products
  logic signed [PROD_W-1:0] s2_pi, s2_pq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_pi <= PROD_W'(s1_x) * PROD_W'(s1_cos);
      s2_pq <= PROD_W'(s1_x) * PROD_W'(s1_nsin);
    end
  end

  // stage 3: round half up, saturate to 32 bits
  function automatic logic signed [31:0] round_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + RND_HALF) >>> TABLE_FRAC_BITS;
    if (r > SAT_HI) begin
      return MAX32;
    end else if (r < SAT_LO) begin
      return MIN32;
    end
    return r[31:0];
  endfunction

  logic signed [31:0] s3_mi, s3_mq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_mi <= round_sat(s2_pi);
      s3_mq <= round_sat(s2_pq);
    end
  end

  // boxcar pairing and output register
  logic signed [31:0] held_i, held_q;
  logic signed [33:0] sum_i, sum_q;
  logic signed [31:0] iv, qv, qv_inv;

  assign sum_i  = 34'(held_i) + 34'(s3_mi) + 34'sd1;
  assign sum_q  = 34'(held_q) + 34'(s3_mq) + 34'sd1;
  assign iv     = sum_i[32:1];
  assign qv     = sum_q[32:1];
  // negating the most negative value saturates
  assign qv_inv = !q_invert ? qv : (qv == MIN32) ? MAX32 : -qv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_second <= 1'b0;
    end else if (s3_fire) begin
      pair_second <= !pair_second;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire && !pair_second) begin
      held_i <= s3_mi;
      held_q <= s3_mq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (s3_fire && pair_second) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire && pair_second) begin
      i_out <= iq_exchange ? qv_inv : iv;
      q_out <= iq_exchange ? iv : qv_inv;
    end
  end

  // checks
  a_phase_on_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> phase_acc == $past(phase_acc + phase_step))
    else $error("phase did not advance on input transfer");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(phase_acc))
    else $error("phase moved without input transfer");

  a_pair_toggle: assert property (@(posedge clk) disable iff (rst)
    s3_fire |=> pair_second != $past(pair_second))
    else $error("pair flag out of step");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (s3_fire && pair_second) |=> out_valid && !pair_second)
    else $error("second sample of pair gave no result");

endmodule
